// File: rtl/cmdlx_pkg.sv
// shared types, codes and command name table for the command pipeline lexer
package cmdlx_pkg;

  // default limits
  localparam int DEF_MAX_STAGES         = 8;
  localparam int DEF_MAX_ARGS           = 8;
  localparam int DEF_TOKEN_BUFFER_BYTES = 256;

  // status and error codes (error code zero means no error yet)
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_EMPTY        = 3'd1;
  localparam logic [2:0] ST_PARSE        = 3'd2;
  localparam logic [2:0] ST_FORBIDDEN    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN_CMD  = 3'd3;
  localparam logic [2:0] ST_STAGES       = 3'd4;
  localparam logic [2:0] ST_ARGS         = 3'd5;

  // special bytes
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // command names: cat nl head tail wc sort grep sed
  localparam int NUM_CMDS = 8;
  localparam logic [7:0] NAME_CHARS [NUM_CMDS][4] = '{
    '{"c", "a", "t", 8'h00},
    '{"n", "l", 8'h00, 8'h00},
    '{"h", "e", "a", "d"},
    '{"t", "a", "i", "l"},
    '{"w", "c", 8'h00, 8'h00},
    '{"s", "o", "r", "t"},
    '{"g", "r", "e", "p"},
    '{"s", "e", "d", 8'h00}
  };
  localparam logic [2:0] NAME_LEN [NUM_CMDS] = '{
    3'd3, 3'd2, 3'd4, 3'd4, 3'd2, 3'd4, 3'd4, 3'd3
  };

  // lexer modes
  typedef enum logic [2:0] {
    LX_IDLE,
    LX_UNQ,
    LX_UNQ_ESC,
    LX_SQ,
    LX_DQ,
    LX_DQ_ESC
  } lex_mode_t;

  // one input request
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } item_t;

  // one result
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_end;
    logic [2:0] stage_index;
    logic [2:0] arg_index;
    logic [2:0] cmd_kind;
    logic       done_res;
    logic [2:0] status;
  } result_t;

endpackage

// File: rtl/cmdlx_if.sv
// valid/ready channel interfaces for input bytes and lexer results
interface cmdlx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       last;

  modport source (output valid, output ch, output has_char, output last, input ready);
  modport sink   (input valid, input ch, input has_char, input last, output ready);
endinterface

interface cmdlx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       token_end;
  logic [2:0] stage_index;
  logic [2:0] arg_index;
  logic [2:0] cmd_kind;
  logic       done_res;
  logic [2:0] status;

  modport source (
    output valid, output out_char, output char_valid, output token_end,
    output stage_index, output arg_index, output cmd_kind, output done_res,
    output status, input ready
  );
  modport sink (
    input valid, input out_char, input char_valid, input token_end,
    input stage_index, input arg_index, input cmd_kind, input done_res,
    input status, output ready
  );
endinterface

// File: rtl/cmdlx_core.sv
// lexer state registers and the single-pass step logic for one byte
module cmdlx_core #(
  parameter int MAX_STAGES         = cmdlx_pkg::DEF_MAX_STAGES,
  parameter int MAX_ARGS           = cmdlx_pkg::DEF_MAX_ARGS,
  parameter int TOKEN_BUFFER_BYTES = cmdlx_pkg::DEF_TOKEN_BUFFER_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  cmdlx_pkg::item_t   item,
  output cmdlx_pkg::result_t res
);
  import cmdlx_pkg::*;

  localparam logic [3:0] ST_LIMIT = 4'(MAX_STAGES);
  localparam logic [3:0] AT_LIMIT = 4'(MAX_ARGS);
  localparam logic [8:0] TL_LIMIT = 9'(TOKEN_BUFFER_BYTES);

  // actions decoded from the current mode and byte
  typedef struct packed {
    lex_mode_t  mode;
    logic [2:0] err;
    logic       new_stage;
    logic       open_tok;
    logic       app;
    logic       fin;
    logic       pipe;
  } lex_act_t;

  lex_mode_t  mode_r, mode_nxt;
  logic       ass_r, ass_nxt;
  logic [7:0] tl_r, tl_nxt;
  logic [3:0] st_r, st_nxt;
  logic [3:0] at_r, at_nxt;
  logic [7:0] mask_r, mask_nxt;
  logic [2:0] fe_r, fe_nxt;
  logic       fb_r, fb_nxt;

  lex_act_t   act;
  logic       fin_now;
  logic       found;
  logic [2:0] kind_sel;
  logic [7:0] o_char;
  logic       o_valid;
  logic       o_end;
  logic [2:0] o_si;
  logic [2:0] o_ai;
  logic [2:0] o_kind;
  logic [2:0] status;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_forbidden(input logic [7:0] c);
    return (c == CH_SEMI) || (c == CH_AMP) || (c == CH_GT) || (c == CH_LT) ||
           (c == CH_DOLLAR) || (c == CH_BTICK) || (c == CH_LF) || (c == CH_CR);
  endfunction

  // running count minus one, zero when nothing has begun
  function automatic logic [2:0] cur_idx(input logic [3:0] n);
    logic [3:0] m;
    m = n - 4'd1;
    return (n == 4'd0) ? 3'd0 : m[2:0];
  endfunction

  // lexer mode decode: next mode and actions for this byte
  always_comb begin
    act      = '0;
    act.mode = mode_r;
    act.err  = ERR_NONE;
    if (item.has_char && (fe_r == ERR_NONE)) begin
      case (mode_r)
        LX_IDLE: begin
          if (!is_space(item.ch)) begin
            if (item.ch == CH_PIPE) begin
              if (ass_r) begin
                act.err = (st_r >= ST_LIMIT) ? ST_STAGES : ST_PARSE;
              end else begin
                act.pipe = 1'b1;
              end
            end else if (ass_r && (st_r >= ST_LIMIT)) begin
              act.err = ST_STAGES;
            end else if (!ass_r && (at_r >= AT_LIMIT)) begin
              act.err = ST_ARGS;
            end else begin
              act.new_stage = ass_r;
              act.open_tok  = 1'b1;
              if (item.ch == CH_SQUOTE) begin
                act.mode = LX_SQ;
              end else if (item.ch == CH_DQUOTE) begin
                act.mode = LX_DQ;
              end else if (item.ch == CH_BSLASH) begin
                act.mode = LX_UNQ_ESC;
              end else begin
                act.mode = LX_UNQ;
                act.app  = 1'b1;
              end
            end
          end
        end
        LX_UNQ: begin
          if (is_space(item.ch)) begin
            act.fin  = 1'b1;
            act.mode = LX_IDLE;
          end else if (item.ch == CH_PIPE) begin
            act.fin  = 1'b1;
            act.pipe = 1'b1;
            act.mode = LX_IDLE;
          end else if (item.ch == CH_BSLASH) begin
            act.mode = LX_UNQ_ESC;
          end else begin
            act.app = 1'b1;
          end
        end
        LX_UNQ_ESC: begin
          act.mode = LX_UNQ;
          act.app  = 1'b1;
        end
        LX_SQ: begin
          if (item.ch == CH_SQUOTE) begin
            if (tl_r == 8'd0) begin
              act.err = ST_PARSE;
            end else begin
              act.fin  = 1'b1;
              act.mode = LX_IDLE;
            end
          end else begin
            act.app = 1'b1;
          end
        end
        LX_DQ: begin
          if (item.ch == CH_DQUOTE) begin
            if (tl_r == 8'd0) begin
              act.err = ST_PARSE;
            end else begin
              act.fin  = 1'b1;
              act.mode = LX_IDLE;
            end
          end else if (item.ch == CH_BSLASH) begin
            act.mode = LX_DQ_ESC;
          end else begin
            act.app = 1'b1;
          end
        end
        LX_DQ_ESC: begin
          act.mode = LX_DQ;
          act.app  = 1'b1;
        end
        default: begin
          act.mode = LX_IDLE;
        end
      endcase
    end
  end

  // token datapath, name match, error tracking and result
  always_comb begin
    mode_nxt = act.mode;
    ass_nxt  = ass_r;
    tl_nxt   = tl_r;
    st_nxt   = st_r;
    at_nxt   = at_r;
    mask_nxt = mask_r;
    fe_nxt   = fe_r;
    fb_nxt   = fb_r;
    o_char   = '0;
    o_valid  = 1'b0;
    o_end    = 1'b0;
    o_si     = '0;
    o_ai     = '0;
    o_kind   = '0;
    fin_now  = act.fin;
    found    = 1'b0;
    kind_sel = '0;

    if (item.has_char && is_forbidden(item.ch)) begin
      fb_nxt = 1'b1;
    end

    // error raised by the decode
    if (act.err != ERR_NONE) begin
      fe_nxt = act.err;
    end

    // stage and token opening
    if (act.new_stage) begin
      st_nxt  = st_r + 4'd1;
      at_nxt  = '0;
      ass_nxt = 1'b0;
    end
    if (act.open_tok) begin
      at_nxt   = at_nxt + 4'd1;
      tl_nxt   = '0;
      mask_nxt = '1;
    end

    // byte append with length check and name narrowing
    if (act.app) begin
      if (({1'b0, tl_nxt} + 9'd1) >= TL_LIMIT) begin
        fe_nxt = ST_PARSE;
      end else begin
        for (int i = 0; i < NUM_CMDS; i++) begin
          if (!((tl_nxt < {5'b0, NAME_LEN[i]}) && (NAME_CHARS[i][tl_nxt[1:0]] == item.ch))) begin
            mask_nxt[i] = 1'b0;
          end
        end
        tl_nxt  = tl_nxt + 8'd1;
        o_char  = item.ch;
        o_valid = 1'b1;
        o_si    = cur_idx(st_nxt);
        o_ai    = cur_idx(at_nxt);
      end
    end

    // end of command: close a bare token, anything else open is a parse error
    if (item.last && (fe_nxt == ERR_NONE)) begin
      if (act.mode == LX_UNQ) begin
        fin_now = 1'b1;
      end else if (act.mode != LX_IDLE) begin
        fe_nxt  = ST_PARSE;
        o_valid = 1'b0;
        o_end   = 1'b0;
        o_char  = '0;
      end
    end

    // token end and command name lookup
    if (fin_now) begin
      o_end = 1'b1;
      o_si  = cur_idx(st_nxt);
      o_ai  = cur_idx(at_nxt);
      if (at_nxt == 4'd1) begin
        for (int i = NUM_CMDS - 1; i >= 0; i--) begin
          if (mask_nxt[i] && (tl_nxt == {5'b0, NAME_LEN[i]})) begin
            found    = 1'b1;
            kind_sel = 3'(i);
          end
        end
        if (found) begin
          o_kind = kind_sel;
        end else begin
          if (fe_nxt == ERR_NONE) begin
            fe_nxt = ST_UNKNOWN_CMD;
          end
          o_valid = 1'b0;
          o_end   = 1'b0;
          o_char  = '0;
          o_kind  = '0;
        end
      end
    end

    // pipe closes the stage
    if (act.pipe) begin
      ass_nxt = 1'b1;
      at_nxt  = '0;
    end

    if (!o_valid && !o_end) begin
      o_si = cur_idx(st_nxt);
      o_ai = cur_idx(at_nxt);
    end

    // running status
    if (fb_nxt) begin
      status = ST_FORBIDDEN;
    end else if (fe_nxt != ERR_NONE) begin
      status = fe_nxt;
    end else begin
      status = (st_nxt != 4'd0) ? ST_OK : ST_EMPTY;
    end

    res.out_char    = o_char;
    res.char_valid  = o_valid;
    res.token_end   = o_end;
    res.stage_index = o_si;
    res.arg_index   = o_ai;
    res.cmd_kind    = (o_end && (o_ai == 3'd0)) ? o_kind : 3'd0;
    res.done_res    = item.last;
    res.status      = status;

    // the last byte clears everything for the next command
    if (item.last) begin
      mode_nxt = LX_IDLE;
      ass_nxt  = 1'b1;
      tl_nxt   = '0;
      st_nxt   = '0;
      at_nxt   = '0;
      mask_nxt = '1;
      fe_nxt   = ERR_NONE;
      fb_nxt   = 1'b0;
    end
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= LX_IDLE;
      ass_r  <= 1'b1;
      tl_r   <= '0;
      st_r   <= '0;
      at_r   <= '0;
      mask_r <= '1;
      fe_r   <= ERR_NONE;
      fb_r   <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      ass_r  <= ass_nxt;
      tl_r   <= tl_nxt;
      st_r   <= st_nxt;
      at_r   <= at_nxt;
      mask_r <= mask_nxt;
      fe_r   <= fe_nxt;
      fb_r   <= fb_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last |=> (mode_r == LX_IDLE) && (st_r == 4'd0) && (fe_r == ERR_NONE) && !fb_r)
    else $error("lexer state not cleared after last byte");

  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r <= ST_LIMIT)
    else $error("stage count above limit");

  a_arg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    at_r <= AT_LIMIT)
    else $error("argument count above limit");

  a_quiet_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    step && (fe_r != ERR_NONE) |-> !res.char_valid && !res.token_end)
    else $error("token output after a sticky error");

  // a forbidden byte may still outrank the stored error
  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    step && (fe_r != ERR_NONE) |-> (res.status == fe_r) || (res.status == ST_FORBIDDEN))
    else $error("status differs from the first error");
`endif

endmodule

// File: rtl/command_pipeline_lexer.sv
// top level of the command pipeline lexer: input register, lexer core, result register
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  in_req   | in  | ch, has_char, last                        | valid/ready
//  out_res  | out | out_char, char_valid, token_end,          | valid/ready
//           |     | stage_index, arg_index, cmd_kind,         |
//           |     | done_res, status                          |
//
// one request per cycle sustained while results are taken; a result is valid once its request has passed
// through the input register, then one lexer step into the result register
// the lexer step is a single level of decode and compare between those registers
// reset clears the lexer state and both valid flags; there is no clearing pass
// a stalled result holds the lexer step; the input register keeps taking requests
// until it is full, so ready only drops while both registers are occupied
module command_pipeline_lexer #(
  parameter int MAX_STAGES         = cmdlx_pkg::DEF_MAX_STAGES,
  parameter int MAX_ARGS           = cmdlx_pkg::DEF_MAX_ARGS,
  parameter int TOKEN_BUFFER_BYTES = cmdlx_pkg::DEF_TOKEN_BUFFER_BYTES
) (
  input logic          clk,
  input logic          rst_n,
  cmdlx_in_if.sink     in_req,
  cmdlx_out_if.source  out_res
);
  import cmdlx_pkg::*;

  logic    in_v_r, in_v_nxt;
  item_t   in_item_r;
  logic    out_v_r, out_v_nxt;
  result_t out_r;
  result_t step_res;
  logic    in_take;
  logic    advance;

  // handshake control
  assign advance      = in_v_r && (!out_v_r || out_res.ready);
  assign in_req.ready = !in_v_r || advance;
  assign in_take      = in_req.valid && in_req.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_req.ready) begin
      in_v_nxt = in_req.valid;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.ch       <= in_req.ch;
      in_item_r.has_char <= in_req.has_char;
      in_item_r.last     <= in_req.last;
    end
  end

  // lexer step
  cmdlx_core #(
    .MAX_STAGES         (MAX_STAGES),
    .MAX_ARGS           (MAX_ARGS),
    .TOKEN_BUFFER_BYTES (TOKEN_BUFFER_BYTES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .res   (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= step_res;
    end
  end

  assign out_res.valid       = out_v_r;
  assign out_res.out_char    = out_r.out_char;
  assign out_res.char_valid  = out_r.char_valid;
  assign out_res.token_end   = out_r.token_end;
  assign out_res.stage_index = out_r.stage_index;
  assign out_res.arg_index   = out_r.arg_index;
  assign out_res.cmd_kind    = out_r.cmd_kind;
  assign out_res.done_res    = out_r.done_res;
  assign out_res.status      = out_r.status;

endmodule

// File: verif/command_pipeline_lexer_checker.sv
`timescale 1ns / 100ps
// checker for the command pipeline lexer: predicts each result and compares it
module command_pipeline_lexer_checker (
  input  logic clk,
  input  logic rst_n,
  cmdlx_in_if  in_mon,
  cmdlx_out_if out_mon,
  output int   mismatch_cnt,
  output int   pending_cnt
);
  import cmdlx_pkg::*;

  localparam int STAGE_LIMIT = DEF_MAX_STAGES;
  localparam int ARG_LIMIT   = DEF_MAX_ARGS;
  localparam int TOKEN_LIMIT = DEF_TOKEN_BUFFER_BYTES;

  string cmd_names [8] = '{"cat", "nl", "head", "tail", "wc", "sort", "grep", "sed"};

  // mirrored lexer state
  lex_mode_t   mode_q;
  logic        stage_open_q;
  int unsigned tok_len_q;
  int unsigned stages_q;
  int unsigned args_q;
  logic [7:0]  name_mask_q;
  logic [2:0]  err_q;
  logic        banned_q;

  // result fields built up during one lexer step
  logic [7:0] r_char;
  logic       r_valid;
  logic       r_end;
  logic [2:0] r_si;
  logic [2:0] r_ai;
  logic [2:0] r_kind;

  result_t lex_steps_q [$];
  int      errs;

  function automatic void clear_lexer();
    mode_q       = LX_IDLE;
    stage_open_q = 1'b1;
    tok_len_q    = 0;
    stages_q     = 0;
    args_q       = 0;
    name_mask_q  = 8'hff;
    err_q        = ERR_NONE;
    banned_q     = 1'b0;
  endfunction

  function automatic logic [2:0] cur_stage();
    return (stages_q != 0) ? 3'(stages_q - 1) : 3'd0;
  endfunction

  function automatic logic [2:0] cur_arg();
    return (args_q != 0) ? 3'(args_q - 1) : 3'd0;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // first error sticks; the step that raises it emits nothing
  function automatic void raise_err(logic [2:0] code);
    if (err_q == ERR_NONE) err_q = code;
    r_valid = 1'b0;
    r_end   = 1'b0;
    r_char  = 8'h00;
    r_kind  = 3'd0;
  endfunction

  // append one token byte and narrow the command name candidates
  function automatic void add_tok_byte(logic [7:0] c);
    int i;
    if (tok_len_q + 1 >= TOKEN_LIMIT) begin
      raise_err(ST_PARSE);
      return;
    end
    for (i = 0; i < 8; i++) begin
      if (!(tok_len_q < cmd_names[i].len() && cmd_names[i][tok_len_q] == c))
        name_mask_q[i] = 1'b0;
    end
    tok_len_q++;
    r_char  = c;
    r_valid = 1'b1;
    r_si    = cur_stage();
    r_ai    = cur_arg();
  endfunction

  // token done; the first token of a stage must name a known command
  function automatic void end_token();
    int i;
    mode_q = LX_IDLE;
    r_end  = 1'b1;
    r_si   = cur_stage();
    r_ai   = cur_arg();
    if (args_q == 1) begin
      for (i = 0; i < 8; i++) begin
        if (name_mask_q[i] && cmd_names[i].len() == tok_len_q) begin
          r_kind = 3'(i);
          return;
        end
      end
      raise_err(ST_UNKNOWN_CMD);
    end
  endfunction

  function automatic void close_quoted();
    if (tok_len_q == 0) raise_err(ST_PARSE);
    else end_token();
  endfunction

  // one command byte through the lexer
  function automatic result_t predict_step(item_t it);
    result_t    r;
    logic [7:0] c;
    c       = it.ch;
    r_char  = 8'h00;
    r_valid = 1'b0;
    r_end   = 1'b0;
    r_si    = 3'd0;
    r_ai    = 3'd0;
    r_kind  = 3'd0;

    if (it.has_char) begin
      if (c inside {CH_SEMI, CH_AMP, CH_GT, CH_LT, CH_DOLLAR, CH_BTICK, CH_LF, CH_CR})
        banned_q = 1'b1;
      if (err_q == ERR_NONE) begin
        case (mode_q)
          LX_IDLE: if (!is_blank(c)) begin
            if (c == CH_PIPE) begin
              if (stage_open_q) begin
                raise_err((stages_q >= STAGE_LIMIT) ? ST_STAGES : ST_PARSE);
              end else begin
                stage_open_q = 1'b1;
                args_q       = 0;
              end
            end else if (stage_open_q && stages_q >= STAGE_LIMIT) begin
              raise_err(ST_STAGES);
            end else if (!stage_open_q && args_q >= ARG_LIMIT) begin
              raise_err(ST_ARGS);
            end else begin
              if (stage_open_q) begin
                stages_q++;
                args_q       = 0;
                stage_open_q = 1'b0;
              end
              args_q++;
              tok_len_q   = 0;
              name_mask_q = 8'hff;
              if (c == CH_SQUOTE) mode_q = LX_SQ;
              else if (c == CH_DQUOTE) mode_q = LX_DQ;
              else if (c == CH_BSLASH) mode_q = LX_UNQ_ESC;
              else begin
                mode_q = LX_UNQ;
                add_tok_byte(c);
              end
            end
          end
          LX_UNQ: begin
            if (is_blank(c)) begin
              end_token();
            end else if (c == CH_PIPE) begin
              end_token();
              stage_open_q = 1'b1;
              args_q       = 0;
            end else if (c == CH_BSLASH) begin
              mode_q = LX_UNQ_ESC;
            end else begin
              add_tok_byte(c);
            end
          end
          LX_UNQ_ESC: begin
            mode_q = LX_UNQ;
            add_tok_byte(c);
          end
          LX_SQ: begin
            if (c == CH_SQUOTE) close_quoted();
            else add_tok_byte(c);
          end
          LX_DQ: begin
            if (c == CH_DQUOTE) close_quoted();
            else if (c == CH_BSLASH) mode_q = LX_DQ_ESC;
            else add_tok_byte(c);
          end
          LX_DQ_ESC: begin
            mode_q = LX_DQ;
            add_tok_byte(c);
          end
          default: mode_q = LX_IDLE;
        endcase
      end
    end

    // end of command: a bare word closes, anything still open is a parse error
    if (it.last && err_q == ERR_NONE) begin
      if (mode_q == LX_UNQ) end_token();
      else if (mode_q != LX_IDLE) raise_err(ST_PARSE);
    end
    if (!r_valid && !r_end) begin
      r_si = cur_stage();
      r_ai = cur_arg();
    end

    r.out_char    = r_char;
    r.char_valid  = r_valid;
    r.token_end   = r_end;
    r.stage_index = r_si;
    r.arg_index   = r_ai;
    r.cmd_kind    = (r_end && r_ai == 3'd0) ? r_kind : 3'd0;
    r.done_res    = it.last;
    if (banned_q) r.status = ST_FORBIDDEN;
    else if (err_q != ERR_NONE) r.status = err_q;
    else r.status = (stages_q != 0) ? ST_OK : ST_EMPTY;

    if (it.last) clear_lexer();
    return r;
  endfunction

  function automatic string res_text(result_t r);
    return $sformatf("char=%h valid=%b end=%b stage=%0d arg=%0d kind=%0d done=%b status=%0d",
                     r.out_char, r.char_valid, r.token_end, r.stage_index, r.arg_index,
                     r.cmd_kind, r.done_res, r.status);
  endfunction

  // predict on every accepted request, compare every accepted result
  always @(posedge clk) begin : watch
    item_t   got_item;
    result_t seen;
    result_t want;
    if (!rst_n) begin
      clear_lexer();
      lex_steps_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        got_item = {in_mon.ch, in_mon.has_char, in_mon.last};
        lex_steps_q.push_back(predict_step(got_item));
      end
      if (out_mon.valid && out_mon.ready) begin
        seen = {out_mon.out_char, out_mon.char_valid, out_mon.token_end,
                out_mon.stage_index, out_mon.arg_index, out_mon.cmd_kind,
                out_mon.done_res, out_mon.status};
        if (lex_steps_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected lexer result: %s", res_text(seen));
        end else begin
          want = lex_steps_q.pop_front();
          if (seen !== want) begin
            errs++;
            if (errs <= 10)
              $display("lexer mismatch: expected %s / got %s", res_text(want), res_text(seen));
          end
        end
      end
    end
    pending_cnt  <= lex_steps_q.size();
    mismatch_cnt <= errs;
  end

endmodule

// File: verif/command_pipeline_lexer_tb.sv
`timescale 1ns / 100ps
// testbench top for the command pipeline lexer: command stimulus, idling and verdict
module command_pipeline_lexer_tb;
  import cmdlx_pkg::*;

  localparam int RANDOM_ITEMS = 250;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [7:0] CH_VT = 8'h0b;
  localparam logic [7:0] CH_FF = 8'h0c;

  logic clk;
  logic rst_n;
  int   mismatch_cnt;
  int   pending_cnt;

  // idling controls, changed per phase
  bit tx_idle;
  bit rx_idle;
  bit pad_idle_bytes;
  int rx_hold_cycles;
  int items_sent;
  int cycle_cnt;

  logic [7:0] cmd_bytes [$];
  string      cmd_words [8] = '{"cat", "nl", "head", "tail", "wc", "sort", "grep", "sed"};
  logic [7:0] banned_bytes [8] = '{CH_SEMI, CH_AMP, CH_GT, CH_LT, CH_DOLLAR, CH_BTICK,
                                   CH_LF, CH_CR};

  cmdlx_in_if  in_req ();
  cmdlx_out_if out_res ();

  command_pipeline_lexer i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  command_pipeline_lexer_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_req),
    .out_mon      (out_res),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls plus one long hold-off at the start of the random part
  initial begin : result_sink
    int stall;
    out_res.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_cycles != 0) begin
        out_res.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        out_res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      do @(posedge clk); while (!(out_res.valid && out_res.ready));
    end
  end

  // offer one request and wait until it is taken
  task automatic offer(input logic [7:0] c, input logic has, input logic fin);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.ch       <= c;
    in_req.has_char <= has;
    in_req.last     <= fin;
    do @(posedge clk); while (!in_req.ready);
    items_sent++;
  endtask

  // stop offering until every predicted result has come back
  task automatic drain();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  // send the built command; the end mark rides on the last byte or on an empty request
  task automatic send_cmd(input bit last_apart);
    int n;
    int k;
    n = cmd_bytes.size();
    for (k = 0; k < n; k++) begin
      if (pad_idle_bytes && $urandom_range(0, 9) == 0)
        offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      offer(cmd_bytes[k], 1'b1, (k == n - 1) && !last_apart);
    end
    if (last_apart || n == 0) offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    cmd_bytes.delete();
  endtask

  function automatic void add_text(string s);
    int k;
    for (k = 0; k < s.len(); k++) cmd_bytes.push_back(s[k]);
  endfunction

  task automatic run_text(input string s, input bit last_apart);
    add_text(s);
    send_cmd(last_apart);
  endtask

  // printable byte with no lexer meaning
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126));
    while (c inside {CH_PIPE, CH_SQUOTE, CH_DQUOTE, CH_BSLASH, CH_SEMI, CH_AMP, CH_GT,
                     CH_LT, CH_DOLLAR, CH_BTICK});
    return c;
  endfunction

  function automatic void add_word(int len);
    int k;
    for (k = 0; k < len; k++) cmd_bytes.push_back(word_char());
  endfunction

  function automatic void add_blank();
    int k;
    logic [7:0] blanks [4];
    blanks = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
    for (k = 0; k < $urandom_range(1, 2); k++)
      cmd_bytes.push_back(($urandom_range(0, 2) == 0) ? blanks[$urandom_range(0, 3)] : CH_SPACE);
  endfunction

  // command name: mostly a known one, sometimes quoted, escaped or misspelled
  function automatic void add_name();
    string w;
    int    pick;
    w    = cmd_words[$urandom_range(0, 7)];
    pick = $urandom_range(0, 19);
    if (pick < 13) begin
      add_text(w);
    end else if (pick == 13) begin
      cmd_bytes.push_back(CH_SQUOTE);
      add_text(w);
      cmd_bytes.push_back(CH_SQUOTE);
    end else if (pick == 14) begin
      cmd_bytes.push_back(CH_DQUOTE);
      add_text(w);
      cmd_bytes.push_back(CH_DQUOTE);
    end else if (pick == 15) begin
      cmd_bytes.push_back(CH_BSLASH);
      add_text(w);
    end else if (pick == 16) begin
      add_text(w.substr(0, w.len() - 2));
    end else if (pick == 17) begin
      add_text(w);
      cmd_bytes.push_back(word_char());
    end else begin
      add_word($urandom_range(1, 5));
    end
  endfunction

  // argument token: plain, quoted, escaped, raw bytes or rarely very long
  function automatic void add_token();
    int pick;
    int k;
    int r;
    if ($urandom_range(0, 199) == 0) begin
      add_word($urandom_range(250, 258));
      return;
    end
    pick = $urandom_range(0, 39);
    if (pick < 24) begin
      add_word($urandom_range(1, 6));
    end else if (pick < 29) begin
      cmd_bytes.push_back(CH_SQUOTE);
      for (k = 0; k < $urandom_range(0, 6); k++) begin
        r = $urandom_range(0, 5);
        if (r == 0) cmd_bytes.push_back(CH_SPACE);
        else if (r == 1) cmd_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_DQUOTE : CH_BSLASH);
        else cmd_bytes.push_back(word_char());
      end
      cmd_bytes.push_back(CH_SQUOTE);
    end else if (pick < 34) begin
      cmd_bytes.push_back(CH_DQUOTE);
      for (k = 0; k < $urandom_range(0, 6); k++) begin
        r = $urandom_range(0, 5);
        if (r == 0) begin
          cmd_bytes.push_back(CH_BSLASH);
          cmd_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_DQUOTE : CH_BSLASH);
        end else if (r == 1) begin
          cmd_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_SQUOTE);
        end else begin
          cmd_bytes.push_back(word_char());
        end
      end
      cmd_bytes.push_back(CH_DQUOTE);
    end else if (pick < 38) begin
      for (k = 0; k < $urandom_range(1, 3); k++) begin
        add_word($urandom_range(0, 2));
        cmd_bytes.push_back(CH_BSLASH);
        cmd_bytes.push_back(8'($urandom_range(1, 255)));
      end
    end else begin
      for (k = 0; k < $urandom_range(1, 4); k++) cmd_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // pipeline with random content, sometimes over the stage or argument limit or ending in a pipe
  function automatic void add_pipeline();
    int n_st;
    int n_arg;
    int s;
    int a;
    n_st = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 9) : $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0) add_blank();
    for (s = 0; s < n_st; s++) begin
      if (s != 0) begin
        if ($urandom_range(0, 1) == 0) add_blank();
        cmd_bytes.push_back(CH_PIPE);
        if ($urandom_range(0, 1) == 0) add_blank();
      end
      add_name();
      n_arg = ($urandom_range(0, 11) == 0) ? $urandom_range(7, 8) : $urandom_range(0, 3);
      for (a = 0; a < n_arg; a++) begin
        add_blank();
        add_token();
      end
    end
    case ($urandom_range(0, 7))
      0: add_blank();
      1: begin
        cmd_bytes.push_back(CH_PIPE);
        add_blank();
      end
      default: ;
    endcase
  endfunction

  // damage a built command in one of several ways
  function automatic void break_cmd();
    int pos;
    pos = $urandom_range(0, cmd_bytes.size());
    case ($urandom_range(0, 5))
      0: cmd_bytes.insert(pos, banned_bytes[$urandom_range(0, 7)]);
      1: if (cmd_bytes.size() > 1) void'(cmd_bytes.pop_back());
      2: cmd_bytes.push_back(CH_BSLASH);
      3: cmd_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_SQUOTE : CH_DQUOTE);
      4: cmd_bytes.push_front(CH_PIPE);
      default: begin
        cmd_bytes.insert(pos, CH_PIPE);
        cmd_bytes.insert(pos, CH_PIPE);
      end
    endcase
  endfunction

  initial begin : stimulus
    int rand_start;
    int cmd_cnt;
    int pick;
    int k;
    rst_n           <= 1'b0;
    in_req.valid    <= 1'b0;
    in_req.ch       <= 8'h00;
    in_req.has_char <= 1'b0;
    in_req.last     <= 1'b0;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    pad_idle_bytes  = 1'b0;
    rx_hold_cycles  = 0;
    items_sent      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty command, names, quoting and escapes
    send_cmd(1'b1);
    run_text("cat", 1'b0);
    run_text("nl a|head -n 1 | tail", 1'b1);
    run_text("grep 'x y' \"a\\\"b\" c\\ d|sort|wc|sed s", 1'b0);
    run_text("\\cat x", 1'b0);
    run_text("\"cat\" x", 1'b0);
    run_text("cat 'ab'cd \"ef\"gh", 1'b0);
    run_text("tail ab'c d\"e", 1'b0);
    run_text("cat | ", 1'b1);
    add_text("wc");
    cmd_bytes.push_back(CH_TAB);
    add_text("x");
    cmd_bytes.push_back(CH_VT);
    add_text("y");
    cmd_bytes.push_back(CH_FF);
    add_text("z");
    send_cmd(1'b1);
    // zero byte and high bytes are ordinary token bytes
    add_text("sort a");
    cmd_bytes.push_back(8'h00);
    add_text("b ");
    cmd_bytes.push_back(8'hff);
    cmd_bytes.push_back(8'h80);
    cmd_bytes.push_back(8'h7f);
    send_cmd(1'b0);

    // forbidden bytes, plain, quoted and over another error
    run_text("cat;x", 1'b0);
    run_text("cat 'a$b'", 1'b0);
    run_text("ls a;", 1'b0);
    add_text("head x");
    cmd_bytes.push_back(CH_LF);
    add_text("y");
    cmd_bytes.push_back(CH_CR);
    send_cmd(1'b0);

    // parse, unknown command, stage and argument limits
    run_text("ls a", 1'b0);
    run_text("cats ca", 1'b0);
    run_text("ca", 1'b1);
    run_text("cat ''", 1'b0);
    run_text("cat \"\"", 1'b0);
    run_text("'' x", 1'b0);
    run_text("| cat", 1'b0);
    run_text("cat ||x", 1'b0);
    run_text("cat 'abc", 1'b1);
    run_text("cat ab\\", 1'b0);
    run_text("sed \"a\\", 1'b0);
    run_text("cat|nl|head|tail|wc|sort|grep|sed|cat", 1'b0);
    run_text("cat|nl|head|tail|wc|sort|grep|sed||", 1'b0);
    run_text("cat a b c d e f g", 1'b0);
    run_text("cat a b c d e f g h", 1'b0);
    // longest token that fits, then one byte over
    add_text("cat ");
    add_word(255);
    send_cmd(1'b0);
    add_text("cat ");
    add_word(256);
    send_cmd(1'b1);

    // let everything come back before the random part
    drain();

    // random commands in phases of different idling
    pad_idle_bytes = 1'b1;
    rand_start     = items_sent;
    cmd_cnt        = 0;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      if (cmd_cnt % 8 == 0) begin
        if (cmd_cnt != 0 && $urandom_range(0, 2) == 0) drain();
        case (cmd_cnt / 8)
          0: begin
            // back-to-back requests against a long result hold-off
            tx_idle        = 1'b0;
            rx_idle        = 1'b0;
            rx_hold_cycles = HOLD_CYCLES;
          end
          default: begin
            tx_idle = $urandom_range(0, 1);
            rx_idle = $urandom_range(0, 1);
          end
        endcase
      end
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        for (k = 0; k < $urandom_range(0, 10); k++)
          cmd_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        add_pipeline();
        if (pick < 6) break_cmd();
      end
      send_cmd($urandom_range(0, 3) == 0);
      cmd_cnt++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cmdlx_pkg.sv
rtl/cmdlx_if.sv
rtl/cmdlx_core.sv
rtl/command_pipeline_lexer.sv
verif/command_pipeline_lexer_checker.sv
verif/command_pipeline_lexer_tb.sv
